// ===== rtl/core/mstb_pkg.sv =====
// package: types and constants for the multi-slot timer bank
`timescale 1ns / 1ps

package mstb_pkg;

    localparam int TIMER_SLOTS   = 16;
    localparam int OP_W          = 3;
    localparam int IDX_W         = 4;
    localparam int DELAY_W       = 20;
    localparam int EXP_IDX_W     = 5;
    localparam int WAIT_W        = 32;
    localparam int TIME_W        = 32;
    localparam int BEST_W        = TIME_W + 1;
    localparam int MAX_WAIT_W    = 8;

    localparam logic [MAX_WAIT_W-1:0] MAX_WAIT_RESET = MAX_WAIT_W'(100);
    localparam logic [EXP_IDX_W-1:0]  NO_SLOT        = EXP_IDX_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_ADD    = 3'd1,
        OP_CANCEL = 3'd2,
        OP_CHECK  = 3'd3,
        OP_NEXT   = 3'd4
    } t_opcode;

    // search token handed from cell to cell
    typedef struct packed {
        logic                        valid;
        logic                        is_check;
        logic                        found;
        logic [EXP_IDX_W-1:0]        found_idx;
        logic [EXP_IDX_W-1:0]        pos;
        logic signed [BEST_W-1:0]    best;
    } t_probe;

    // write controls from the command decode to one cell
    typedef struct packed {
        logic                        arm;
        logic                        disarm;
    } t_cell_ctl;

endpackage

// ===== rtl/core/mstb_cell.sv =====
// cell: one timer slot plus one stage of the search token chain
`timescale 1ns / 1ps

module mstb_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mstb_pkg::t_cell_ctl            i_ctl,
    input  logic [mstb_pkg::TIME_W-1:0]    i_expiry_wr,
    input  logic [mstb_pkg::TIME_W-1:0]    i_now,
    input  mstb_pkg::t_probe               i_probe,
    output mstb_pkg::t_probe               o_probe
);

    logic [mstb_pkg::TIME_W-1:0]          r_expiry;
    logic                                 r_armed;
    mstb_pkg::t_probe                     r_probe;
    mstb_pkg::t_probe                     n_probe;
    logic                                 due;
    logic                                 hit;
    logic signed [mstb_pkg::BEST_W-1:0]   rem;

    always_comb begin
        due = r_armed && (i_now >= r_expiry);
        rem = $signed({1'b0, r_expiry}) - $signed({1'b0, i_now});
        hit = i_probe.valid && i_probe.is_check && !i_probe.found && due;
        n_probe = i_probe;
        n_probe.pos = i_probe.pos + mstb_pkg::EXP_IDX_W'(1);
        if (hit) begin
            n_probe.found     = 1'b1;
            n_probe.found_idx = i_probe.pos;
        end
        if (i_probe.valid && !i_probe.is_check && r_armed && (rem < i_probe.best)) begin
            n_probe.best = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed       <= 1'b0;
            r_probe.valid <= 1'b0;
        end else begin
            r_probe <= n_probe;
            if (i_ctl.arm) begin
                r_armed <= 1'b1;
            end else if (i_ctl.disarm || hit) begin
                r_armed <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.arm) begin
            r_expiry <= i_expiry_wr;
        end
    end

    assign o_probe = r_probe;

endmodule

// ===== rtl/core/multi_slot_timer_bank.sv =====
// top level: command decode, seconds counter, cell chain and result register
//
//   channel  | direction | handshake                   | payload
//   in       | in        | i_in_valid / o_in_stall     | opcode, timer_index, delay_seconds
//   out      | out       | o_out_valid / i_out_stall   | expired_index, wait_seconds
//   cfg      | in        | i_cfg_valid / o_cfg_ready   | max_wait
//
// tick, add and cancel finish in the cycle after the beat; their result goes through S_DONE
// to the output register. check and next send a token down the row of TIMER_SLOTS cells,
// one cell a cycle, each cell registering it; their result then goes through S_DONE too.
// one item is in flight at a time; the next beat is taken while a result waits on stall.
// synchronous active-low reset clears the counter, the armed bits and max_wait to 100.
`timescale 1ns / 1ps

module multi_slot_timer_bank (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [mstb_pkg::OP_W-1:0]           i_opcode,
    input  logic [mstb_pkg::IDX_W-1:0]          i_timer_index,
    input  logic [mstb_pkg::DELAY_W-1:0]        i_delay_seconds,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mstb_pkg::EXP_IDX_W-1:0]      o_expired_index,
    output logic signed [mstb_pkg::WAIT_W-1:0]  o_wait_seconds,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mstb_pkg::MAX_WAIT_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    localparam logic signed [mstb_pkg::BEST_W-1:0] SAT_MIN =
        -($signed({1'b0, 1'b1, {(mstb_pkg::WAIT_W-1){1'b0}}}));

    t_state                                  r_state;
    logic [mstb_pkg::MAX_WAIT_W-1:0]         r_max_wait;
    logic [mstb_pkg::TIME_W-1:0]             r_now;
    logic [mstb_pkg::EXP_IDX_W-1:0]          r_res_idx;
    logic signed [mstb_pkg::WAIT_W-1:0]      r_res_wait;
    logic                                    r_out_valid;
    logic [mstb_pkg::EXP_IDX_W-1:0]          r_out_idx;
    logic signed [mstb_pkg::WAIT_W-1:0]      r_out_wait;

    logic                                    in_beat;
    logic                                    out_free;
    logic                                    idx_ok;
    logic [mstb_pkg::TIME_W-1:0]             expiry_wr;
    mstb_pkg::t_cell_ctl                     cell_ctl [mstb_pkg::TIMER_SLOTS];
    mstb_pkg::t_probe                        chain    [mstb_pkg::TIMER_SLOTS+1];
    mstb_pkg::t_probe                        tail;
    logic signed [mstb_pkg::WAIT_W-1:0]      tail_wait;

    assign in_beat     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign idx_ok      = (32'(i_timer_index) < 32'(mstb_pkg::TIMER_SLOTS));
    assign expiry_wr   = r_now + mstb_pkg::TIME_W'(i_delay_seconds);

    always_comb begin
        for (int i = 0; i < mstb_pkg::TIMER_SLOTS; i++) begin
            cell_ctl[i].arm    = in_beat && idx_ok && (i_opcode == mstb_pkg::OP_ADD)
                                 && (32'(i_timer_index) == i);
            cell_ctl[i].disarm = in_beat && idx_ok && (i_opcode == mstb_pkg::OP_CANCEL)
                                 && (32'(i_timer_index) == i);
        end
    end

    always_comb begin
        chain[0].valid     = in_beat && ((i_opcode == mstb_pkg::OP_CHECK)
                                         || (i_opcode == mstb_pkg::OP_NEXT));
        chain[0].is_check  = (i_opcode == mstb_pkg::OP_CHECK);
        chain[0].found     = 1'b0;
        chain[0].found_idx = mstb_pkg::NO_SLOT;
        chain[0].pos       = '0;
        chain[0].best      = $signed({{(mstb_pkg::BEST_W-mstb_pkg::MAX_WAIT_W){1'b0}},
                                      r_max_wait});
    end

    for (genvar g = 0; g < mstb_pkg::TIMER_SLOTS; g++) begin : g_cell
        mstb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl[g]),
            .i_expiry_wr (expiry_wr),
            .i_now       (r_now),
            .i_probe     (chain[g]),
            .o_probe     (chain[g+1])
        );
    end

    assign tail = chain[mstb_pkg::TIMER_SLOTS];

    always_comb begin
        if (tail.best < SAT_MIN) begin
            tail_wait = SAT_MIN[mstb_pkg::WAIT_W-1:0];
        end else begin
            tail_wait = tail.best[mstb_pkg::WAIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_wait  <= mstb_pkg::MAX_WAIT_RESET;
            r_now       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_wait <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        if (i_opcode == mstb_pkg::OP_TICK) begin
                            r_now <= r_now + mstb_pkg::TIME_W'(1);
                        end
                        if (chain[0].valid) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    if (tail.valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_beat) begin
            r_res_idx  <= mstb_pkg::NO_SLOT;
            r_res_wait <= '0;
        end else if (r_state == S_SCAN && tail.valid) begin
            if (tail.is_check) begin
                r_res_idx  <= tail.found ? tail.found_idx : mstb_pkg::NO_SLOT;
                r_res_wait <= '0;
            end else begin
                r_res_idx  <= mstb_pkg::NO_SLOT;
                r_res_wait <= tail_wait;
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_out_idx  <= r_res_idx;
            r_out_wait <= r_res_wait;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_expired_index = r_out_idx;
    assign o_wait_seconds  = r_out_wait;

endmodule

// ===== rtl/core/mstb_chk.sv =====
// checker: port-level assertions for the timer bank, bound to the top level
`timescale 1ns / 1ps

module mstb_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic [mstb_pkg::EXP_IDX_W-1:0]      o_expired_index,
    input  logic signed [mstb_pkg::WAIT_W-1:0]  o_wait_seconds
);

    // one item in flight: busy right after a beat
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a beat");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_expired_index)
                                          && $stable(o_wait_seconds)))
        else $error("stalled result changed");

    // a result carries either a slot or a wait, never both
    a_one_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_expired_index == mstb_pkg::NO_SLOT) || (o_wait_seconds == 0)))
        else $error("slot and wait both reported");

    // reported slot stays in range
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_expired_index <= mstb_pkg::NO_SLOT))
        else $error("expired index out of range");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind multi_slot_timer_bank mstb_chk u_mstb_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_expired_index (o_expired_index),
    .o_wait_seconds  (o_wait_seconds)
);

// ===== test/multi_slot_timer_bank_test.sv =====
// testbench: directed table and random commands for the timer bank, checked against table values or a predictor
`timescale 1ns / 1ps

module multi_slot_timer_bank_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS = 125;
    localparam int PHASES = 8;
    localparam int REPORT_LIMIT = 10;
    localparam longint WAIT_FLOOR = -(longint'(1) << 31);

    localparam logic [mstb_pkg::OP_W-1:0] OP_RSVD_A = 3'd5;
    localparam logic [mstb_pkg::OP_W-1:0] OP_RSVD_B = 3'd6;
    localparam logic [mstb_pkg::OP_W-1:0] OP_RSVD_C = 3'd7;

    typedef struct packed {
        logic [mstb_pkg::EXP_IDX_W-1:0]     slot;
        logic signed [mstb_pkg::WAIT_W-1:0] left;
    } t_bank_result;

    typedef struct {
        logic [mstb_pkg::OP_W-1:0]    op;
        logic [mstb_pkg::IDX_W-1:0]   idx;
        logic [mstb_pkg::DELAY_W-1:0] dly;
        bit                           fixed;
        t_bank_result                 want;
    } t_cmd_row;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic [mstb_pkg::OP_W-1:0]           i_opcode = '0;
    logic [mstb_pkg::IDX_W-1:0]          i_timer_index = '0;
    logic [mstb_pkg::DELAY_W-1:0]        i_delay_seconds = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [mstb_pkg::EXP_IDX_W-1:0]      o_expired_index;
    logic signed [mstb_pkg::WAIT_W-1:0]  o_wait_seconds;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [mstb_pkg::MAX_WAIT_W-1:0]     i_cfg_data = '0;

    // predictor state
    logic [mstb_pkg::TIME_W-1:0]     now_m;
    logic [mstb_pkg::TIME_W-1:0]     slot_expiry [mstb_pkg::TIMER_SLOTS];
    logic                            slot_armed [mstb_pkg::TIMER_SLOTS];
    logic [mstb_pkg::MAX_WAIT_W-1:0] max_wait_m;

    t_bank_result pending_results[$];
    t_cmd_row     cmd_table[$];

    bit no_idle = 1'b0;
    int err_cnt = 0;
    int checked_cnt = 0;
    int sent_cnt = 0;
    int cfg_cnt = 0;
    int hit_cnt = 0;
    int overdue_cnt = 0;
    int idle_cycles = 0;

    multi_slot_timer_bank u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_timer_index   (i_timer_index),
        .i_delay_seconds (i_delay_seconds),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_expired_index (o_expired_index),
        .o_wait_seconds  (o_wait_seconds),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_bank_result timer_bank_step(
            input logic [mstb_pkg::OP_W-1:0] op,
            input logic [mstb_pkg::IDX_W-1:0] idx,
            input logic [mstb_pkg::DELAY_W-1:0] dly);
        t_bank_result r;
        longint best;
        longint gap;
        bit hunting;
        r.slot = mstb_pkg::NO_SLOT;
        r.left = '0;
        hunting = 1'b1;
        case (op)
            mstb_pkg::OP_TICK: begin
                now_m = now_m + 1'b1;
            end
            mstb_pkg::OP_ADD: begin
                if (int'(idx) < mstb_pkg::TIMER_SLOTS) begin
                    slot_expiry[idx] = now_m + mstb_pkg::TIME_W'(dly);
                    slot_armed[idx] = 1'b1;
                end
            end
            mstb_pkg::OP_CANCEL: begin
                if (int'(idx) < mstb_pkg::TIMER_SLOTS) slot_armed[idx] = 1'b0;
            end
            mstb_pkg::OP_CHECK: begin
                for (int i = 0; i < mstb_pkg::TIMER_SLOTS; i++) begin
                    if (hunting && slot_armed[i] && now_m >= slot_expiry[i]) begin
                        slot_armed[i] = 1'b0;
                        r.slot = mstb_pkg::EXP_IDX_W'(i);
                        hunting = 1'b0;
                    end
                end
            end
            mstb_pkg::OP_NEXT: begin
                best = longint'(max_wait_m);
                for (int i = 0; i < mstb_pkg::TIMER_SLOTS; i++) begin
                    gap = longint'(slot_expiry[i]) - longint'(now_m);
                    if (slot_armed[i] && gap < best) best = gap;
                end
                if (best < WAIT_FLOOR) best = WAIT_FLOOR;
                r.left = mstb_pkg::WAIT_W'(best);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void add_row(input logic [mstb_pkg::OP_W-1:0] op,
                                    input logic [mstb_pkg::IDX_W-1:0] idx,
                                    input logic [mstb_pkg::DELAY_W-1:0] dly,
                                    input bit fixed,
                                    input logic [mstb_pkg::EXP_IDX_W-1:0] slot,
                                    input logic signed [mstb_pkg::WAIT_W-1:0] left);
        t_cmd_row row;
        row.op = op;
        row.idx = idx;
        row.dly = dly;
        row.fixed = fixed;
        row.want.slot = slot;
        row.want.left = left;
        cmd_table.push_back(row);
    endfunction

    // one command beat; valid stays high afterwards until the caller moves on
    task automatic send_cmd(input t_cmd_row row);
        t_bank_result pred;
        if (!no_idle && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 60);
        end
        i_in_valid <= 1'b1;
        i_opcode <= row.op;
        i_timer_index <= row.idx;
        i_delay_seconds <= row.dly;
        do @(posedge i_clk); while (o_in_stall);
        pred = timer_bank_step(row.op, row.idx, row.dly);
        if (pred.slot != mstb_pkg::NO_SLOT) hit_cnt++;
        if (pred.left < 0) overdue_cnt++;
        pending_results.push_back(row.fixed ? row.want : pred);
        sent_cnt++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_max_wait(input logic [mstb_pkg::MAX_WAIT_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        max_wait_m = value;
        cfg_cnt++;
    endtask

    // result side: random stall and compare against the oldest expected result
    always @(posedge i_clk) begin
        t_bank_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(99) < 19);
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_LIMIT)
                        $display("unexpected result beat: slot %0d wait %0d",
                                 o_expired_index, o_wait_seconds);
                end else begin
                    want = pending_results.pop_front();
                    checked_cnt++;
                    if (o_expired_index !== want.slot || o_wait_seconds !== want.left) begin
                        err_cnt++;
                        if (err_cnt <= REPORT_LIMIT)
                            $display({"mismatch on result %0d: slot exp %0d got %0d,",
                                      " wait exp %0d got %0d"},
                                     checked_cnt, want.slot, o_expired_index,
                                     want.left, o_wait_seconds);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        t_cmd_row row;
        int pick;
        logic [mstb_pkg::MAX_WAIT_W-1:0] setting;
        now_m = '0;
        max_wait_m = mstb_pkg::MAX_WAIT_RESET;
        for (int i = 0; i < mstb_pkg::TIMER_SLOTS; i++) begin
            slot_expiry[i] = '0;
            slot_armed[i] = 1'b0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset value of max_wait
        add_row(mstb_pkg::OP_NEXT,   4'd0,  20'd0,     1'b1, mstb_pkg::NO_SLOT,
                mstb_pkg::WAIT_W'(mstb_pkg::MAX_WAIT_RESET));
        add_row(mstb_pkg::OP_CHECK,  4'd0,  20'd0,     1'b1, mstb_pkg::NO_SLOT, 0);
        add_row(OP_RSVD_A,           4'd15, 20'hFFFFF, 1'b1, mstb_pkg::NO_SLOT, 0);
        add_row(OP_RSVD_C,           4'd6,  20'hA5A5A, 1'b1, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_ADD,    4'd0,  20'd0,     1'b1, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_CHECK,  4'd0,  20'd0,     1'b1, 5'd0, 0);
        add_row(mstb_pkg::OP_ADD,    4'd15, 20'hFFFFF, 1'b1, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_NEXT,   4'd0,  20'd0,     1'b1, mstb_pkg::NO_SLOT,
                mstb_pkg::WAIT_W'(mstb_pkg::MAX_WAIT_RESET));
        add_row(mstb_pkg::OP_ADD,    4'd3,  20'd5,     1'b1, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_NEXT,   4'd0,  20'd0,     1'b0, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_TICK,   4'd15, 20'hFFFFF, 1'b1, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_ADD,    4'd3,  20'd2,     1'b0, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_NEXT,   4'd0,  20'd0,     1'b0, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_CANCEL, 4'd3,  20'd0,     1'b1, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_ADD,    4'd7,  20'd0,     1'b0, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_TICK,   4'd0,  20'd0,     1'b0, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_TICK,   4'd0,  20'd0,     1'b0, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_NEXT,   4'd0,  20'd0,     1'b0, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_CHECK,  4'd0,  20'd0,     1'b0, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_ADD,    4'd2,  20'd0,     1'b0, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_ADD,    4'd1,  20'd0,     1'b0, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_CHECK,  4'd0,  20'd0,     1'b0, mstb_pkg::NO_SLOT, 0);
        add_row(mstb_pkg::OP_CANCEL, 4'd15, 20'd0,     1'b1, mstb_pkg::NO_SLOT, 0);
        add_row(OP_RSVD_B,           4'd9,  20'h5A5A5, 1'b1, mstb_pkg::NO_SLOT, 0);
        foreach (cmd_table[i]) send_cmd(cmd_table[i]);

        // random phases, one max_wait setting each
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: setting = 8'd1;
                1: setting = 8'd255;
                2: setting = 8'd0;
                3: setting = 8'hAA;
                4: setting = 8'h55;
                6: setting = mstb_pkg::MAX_WAIT_RESET;
                default: setting = mstb_pkg::MAX_WAIT_W'($urandom);
            endcase
            write_max_wait(setting);
            no_idle = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 60) drain_results();
                row.fixed = 1'b0;
                row.want = '0;
                row.idx = mstb_pkg::IDX_W'($urandom);
                pick = $urandom_range(99);
                if (pick < 70) row.dly = mstb_pkg::DELAY_W'($urandom_range(15));
                else if (pick < 90) row.dly = mstb_pkg::DELAY_W'($urandom_range(300));
                else row.dly = mstb_pkg::DELAY_W'($urandom);
                pick = $urandom_range(99);
                if (pick < 30) row.op = mstb_pkg::OP_TICK;
                else if (pick < 55) row.op = mstb_pkg::OP_ADD;
                else if (pick < 65) row.op = mstb_pkg::OP_CANCEL;
                else if (pick < 80) row.op = mstb_pkg::OP_CHECK;
                else if (pick < 95) row.op = mstb_pkg::OP_NEXT;
                else row.op = mstb_pkg::OP_W'(OP_RSVD_A
                                              + mstb_pkg::OP_W'($urandom_range(2)));
                send_cmd(row);
            end
        end
        no_idle = 1'b0;

        drain_results();
        repeat (mstb_pkg::TIMER_SLOTS + 8) @(posedge i_clk);
        err_cnt += pending_results.size();

        $display("covered %0d commands and %0d checked results over %0d max_wait settings",
                 sent_cnt, checked_cnt, cfg_cnt);
        $display("slots reported expired: %0d, overdue next answers: %0d",
                 hit_cnt, overdue_cnt);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("mismatches and missing results: %0d", err_cnt);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
